FILE: hw/rtl/i2cm_pkg.sv
// Shared types and constants of the I2C master register access unit.
// Used by the channel interfaces, the input queue and the bus sequencer.
package i2cm_pkg;

	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
	localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam int unsigned CFG_INDEX_W = 2;
	localparam int unsigned CFG_DATA_W  = 8;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_START_STOP_HOLD = 2'd0,
		CFG_BIT_PHASE       = 2'd1,
		CFG_STORED_ADDRESS  = 2'd2
	} cfg_reg_t;

	typedef enum logic [1:0] {
		OP_WRITE_ONE   = 2'd0,
		OP_BURST_WRITE = 2'd1,
		OP_READ_ONE    = 2'd2,
		OP_BURST_READ  = 2'd3
	} op_t;

	localparam logic [7:0] HOLD_RESET = 8'd5;
	localparam logic [7:0] BIT_RESET  = 8'd1;

	typedef struct packed {
		logic       request;
		logic [1:0] operation;
		logic       use_stored_address;
		logic [6:0] device_address;
		logic [7:0] register_index;
		logic [7:0] byte_count;
		logic [7:0] write_data;
		logic       sda_in;
	} in_item_t;

	typedef struct packed {
		logic       scl_level;
		logic       sda_level;
		logic       sda_driven;
		logic       busy_res;
		logic       data_taken;
		logic [7:0] read_data;
		logic       read_valid;
		logic       last_byte;
		logic       ack_missing;
	} out_item_t;

	typedef struct packed {
		logic     valid;
		in_item_t item;
	} queue_head_t;

endpackage

FILE: hw/rtl/i2cm_item_if.sv
// Valid/ready channel that carries one tick word into the unit.
// Depends on i2cm_pkg for the word type.
interface i2cm_item_if;
	logic                valid;
	logic                ready;
	i2cm_pkg::in_item_t  payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

FILE: hw/rtl/i2cm_result_if.sv
// Valid/ready channel that carries one result word out of the unit.
// Depends on i2cm_pkg for the word type.
interface i2cm_result_if;
	logic                valid;
	logic                ready;
	i2cm_pkg::out_item_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

FILE: hw/rtl/i2cm_front.sv
// Input side: takes tick words and holds them in a short queue.
// Depends on i2cm_pkg and i2cm_item_if.
module i2cm_front (
	input  logic                  clk,
	input  logic                  arst_n,
	i2cm_item_if.sink             item,
	output i2cm_pkg::queue_head_t head,
	input  logic                  pop
);
	import i2cm_pkg::*;

	in_item_t                 entry_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0]   wr_ptr_q;
	logic [QUEUE_PTR_W-1:0]   rd_ptr_q;
	logic [QUEUE_CNT_W-1:0]   count_q;
	logic                     push;
	logic                     do_pop;

	assign item.ready = (count_q != QUEUE_CNT_W'(QUEUE_DEPTH));
	assign push       = item.valid && item.ready;
	assign head.valid = (count_q != '0);
	assign head.item  = entry_q[rd_ptr_q];
	assign do_pop     = pop && head.valid;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= item.payload;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: hw/rtl/i2cm_back.sv
// Bus sequencer: advances the I2C transaction by one tick per queued word
// and registers the line levels and status. Depends on i2cm_pkg and i2cm_result_if.
module i2cm_back (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [i2cm_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [i2cm_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  i2cm_pkg::queue_head_t                head,
	output logic                                 pop,
	i2cm_result_if.source                        result
);
	import i2cm_pkg::*;

	typedef enum logic [3:0] {
		PH_IDLE, PH_RS_LOW, PH_START_HI, PH_START_LO, PH_WBIT_L, PH_WBIT_H,
		PH_WACK_L, PH_WACK_H, PH_RBIT_L, PH_RBIT_H, PH_RACK_L, PH_RACK_H,
		PH_STOP_PRE, PH_STOP_A, PH_STOP_B
	} phase_t;

	typedef enum logic [2:0] {
		ST_ADDR_W, ST_REG, ST_DATA, ST_ADDR_R, ST_READ, ST_DONE
	} stage_t;

	logic [7:0] hold_ticks_q, bit_ticks_q, stored_addr_q;

	phase_t     phase_q, n_phase;
	stage_t     stage_q, n_stage;
	logic [7:0] tick_q, n_tick, tick_inc;
	logic [3:0] bit_q, n_bit, bit_inc;
	logic [7:0] shift_q, n_shift;
	logic [7:0] bytes_q, n_bytes;
	op_t        op_q, n_op;
	logic [7:0] addr_q, n_addr;
	logic [7:0] reg_q, n_reg;
	logic [7:0] hold, plen;
	logic       ackb;
	in_item_t   it;
	out_item_t  res;
	logic       res_valid_q;
	out_item_t  res_q;

	assign it  = head.item;
	assign pop = head.valid && (!res_valid_q || result.ready);
	assign result.valid   = res_valid_q;
	assign result.payload = res_q;
	assign ackb = (bytes_q <= 8'd1);

	always_comb begin
		n_phase = phase_q;
		n_stage = stage_q;
		n_tick  = tick_q;
		n_bit   = bit_q;
		n_shift = shift_q;
		n_bytes = bytes_q;
		n_op    = op_q;
		n_addr  = addr_q;
		n_reg   = reg_q;
		res     = '0;

		if (phase_q == PH_IDLE && it.request) begin
			n_op    = op_t'(it.operation);
			n_addr  = it.use_stored_address ? stored_addr_q : {it.device_address, 1'b0};
			n_reg   = it.register_index;
			case (op_t'(it.operation))
				OP_WRITE_ONE, OP_READ_ONE: n_bytes = 8'd1;
				OP_BURST_READ:             n_bytes = (it.byte_count == 8'd0) ? 8'd1 : it.byte_count;
				default:                   n_bytes = it.byte_count;
			endcase
			n_stage = ST_ADDR_W;
			n_phase = PH_START_HI;
			n_tick  = '0;
			n_bit   = '0;
		end

		case (n_phase)
			PH_RS_LOW:   {res.scl_level, res.sda_level, res.sda_driven} = 3'b011;
			PH_START_LO: {res.scl_level, res.sda_level, res.sda_driven} = 3'b101;
			PH_WBIT_L:   {res.scl_level, res.sda_level, res.sda_driven} = {1'b0, shift_q[7], 1'b1};
			PH_WBIT_H:   {res.scl_level, res.sda_level, res.sda_driven} = {1'b1, shift_q[7], 1'b1};
			PH_WACK_L:   {res.scl_level, res.sda_level, res.sda_driven} = 3'b010;
			PH_WACK_H:   {res.scl_level, res.sda_level, res.sda_driven} = 3'b110;
			PH_RBIT_L:   {res.scl_level, res.sda_level, res.sda_driven} = 3'b010;
			PH_RBIT_H:   {res.scl_level, res.sda_level, res.sda_driven} = 3'b110;
			PH_RACK_L:   {res.scl_level, res.sda_level, res.sda_driven} = {1'b0, ackb, 1'b1};
			PH_RACK_H:   {res.scl_level, res.sda_level, res.sda_driven} = {1'b1, ackb, 1'b1};
			PH_STOP_PRE: {res.scl_level, res.sda_level, res.sda_driven} = 3'b001;
			PH_STOP_A:   {res.scl_level, res.sda_level, res.sda_driven} = 3'b101;
			default:     {res.scl_level, res.sda_level, res.sda_driven} = 3'b111;
		endcase

		if (n_phase inside {PH_START_HI, PH_START_LO, PH_STOP_A, PH_STOP_B}) begin
			hold = hold_ticks_q;
		end else begin
			hold = bit_ticks_q;
		end
		plen     = (hold == 8'd0) ? 8'd1 : hold;
		tick_inc = n_tick + 8'd1;
		bit_inc  = n_bit + 4'd1;

		if (n_phase != PH_IDLE) begin
			res.busy_res = 1'b1;
			n_tick = tick_inc;
			if (tick_inc >= plen) begin
				n_tick = '0;
				case (n_phase)
					PH_RS_LOW:   n_phase = PH_START_HI;
					PH_START_HI: n_phase = PH_START_LO;
					PH_START_LO: begin
						n_shift = (n_stage == ST_ADDR_R) ? (n_addr | 8'h01) : (n_addr & 8'hFE);
						n_bit   = '0;
						n_phase = PH_WBIT_L;
					end
					PH_WBIT_L:   n_phase = PH_WBIT_H;
					PH_WBIT_H: begin
						n_shift = {shift_q[6:0], 1'b0};
						if (bit_inc >= 4'd8) begin
							n_bit   = '0;
							n_phase = PH_WACK_L;
						end else begin
							n_bit   = bit_inc;
							n_phase = PH_WBIT_L;
						end
					end
					PH_WACK_L:   n_phase = PH_WACK_H;
					PH_WACK_H: begin
						res.ack_missing = it.sda_in;
						if (n_stage == ST_ADDR_W) begin
							n_stage = ST_REG;
							n_shift = n_reg;
							n_phase = PH_WBIT_L;
						end else if (n_stage == ST_ADDR_R) begin
							n_stage = ST_READ;
							n_shift = '0;
							n_bit   = '0;
							n_phase = PH_RBIT_L;
						end else if (n_stage == ST_REG && n_op[1]) begin
							n_stage = ST_ADDR_R;
							n_phase = (n_op == OP_READ_ONE) ? PH_RS_LOW : PH_STOP_PRE;
						end else if (n_bytes != 8'd0) begin
							n_stage = ST_DATA;
							n_shift = it.write_data;
							res.data_taken = 1'b1;
							n_bytes = n_bytes - 8'd1;
							n_phase = PH_WBIT_L;
						end else begin
							n_stage = ST_DONE;
							n_phase = PH_STOP_PRE;
						end
					end
					PH_RBIT_L:   n_phase = PH_RBIT_H;
					PH_RBIT_H: begin
						n_shift = {shift_q[6:0], it.sda_in};
						if (bit_inc >= 4'd8) begin
							n_bit          = '0;
							res.read_valid = 1'b1;
							res.read_data  = {shift_q[6:0], it.sda_in};
							res.last_byte  = ackb;
							n_phase        = PH_RACK_L;
						end else begin
							n_bit   = bit_inc;
							n_phase = PH_RBIT_L;
						end
					end
					PH_RACK_L:   n_phase = PH_RACK_H;
					PH_RACK_H: begin
						if (n_bytes > 8'd1) begin
							n_bytes = n_bytes - 8'd1;
							n_shift = '0;
							n_phase = PH_RBIT_L;
						end else begin
							n_bytes = '0;
							n_stage = ST_DONE;
							n_phase = PH_STOP_PRE;
						end
					end
					PH_STOP_PRE: n_phase = PH_STOP_A;
					PH_STOP_A:   n_phase = PH_STOP_B;
					default:     n_phase = (n_stage == ST_ADDR_R) ? PH_START_HI : PH_IDLE;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			res_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_ticks_q  <= HOLD_RESET;
			bit_ticks_q   <= BIT_RESET;
			stored_addr_q <= '0;
			phase_q       <= PH_IDLE;
			stage_q       <= ST_ADDR_W;
			tick_q        <= '0;
			bit_q         <= '0;
			shift_q       <= '0;
			bytes_q       <= '0;
			op_q          <= OP_WRITE_ONE;
			addr_q        <= '0;
			reg_q         <= '0;
			res_valid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					CFG_START_STOP_HOLD: hold_ticks_q  <= cfg_data;
					CFG_BIT_PHASE:       bit_ticks_q   <= cfg_data;
					CFG_STORED_ADDRESS:  stored_addr_q <= cfg_data;
					default: ;
				endcase
			end
			if (pop) begin
				phase_q <= n_phase;
				stage_q <= n_stage;
				tick_q  <= n_tick;
				bit_q   <= n_bit;
				shift_q <= n_shift;
				bytes_q <= n_bytes;
				op_q    <= n_op;
				addr_q  <= n_addr;
				reg_q   <= n_reg;
			end
			if (pop) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

endmodule

FILE: hw/rtl/i2c_master_register_access_unit.sv
// Top level of the I2C master register access unit: input queue and bus sequencer.
// One tick word is taken per cycle while the result channel takes results; a word is
// registered in the queue, then its result word is registered when the sequencer pops it.
// The unit sustains one word per cycle under that condition, set by the sequencer step behind
// a two-entry queue and a registered output.
// Reset empties the queue, idles the sequencer with clock and data high and driven,
// and loads the timing and address registers with their defaults.
module i2c_master_register_access_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [i2cm_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [i2cm_pkg::CFG_DATA_W-1:0]   cfg_data,
	i2cm_item_if.sink                         item,
	i2cm_result_if.source                     result
);
	import i2cm_pkg::*;

	queue_head_t head;
	logic        pop;

	i2cm_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.head   (head),
		.pop    (pop)
	);

	i2cm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.head      (head),
		.pop       (pop),
		.result    (result)
	);

endmodule

FILE: tb/sv/i2c_master_register_access_unit_tb.sv
// Self-checking testbench of the I2C master register access unit: tick words go in through
// the item channel and every result word is checked against a model of the bus sequencer.
// Depends on i2cm_pkg, i2cm_item_if, i2cm_result_if and the unit itself.
module i2c_master_register_access_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import i2cm_pkg::*;

	typedef enum logic [3:0] {
		SEQ_IDLE, SEQ_RS_LOW, SEQ_START_HI, SEQ_START_LO, SEQ_WBIT_L, SEQ_WBIT_H,
		SEQ_WACK_L, SEQ_WACK_H, SEQ_RBIT_L, SEQ_RBIT_H, SEQ_RACK_L, SEQ_RACK_H,
		SEQ_STOP_PRE, SEQ_STOP_A, SEQ_STOP_B
	} seq_phase_t;

	typedef enum logic [2:0] {
		XFER_ADDR_W, XFER_REG, XFER_DATA, XFER_ADDR_R, XFER_READ, XFER_DONE
	} xfer_stage_t;

	typedef enum {SDA_ACK, SDA_NACK, SDA_NOISE} sda_drive_t;

	typedef struct {
		seq_phase_t  phase;
		logic [7:0]  tick_count;
		logic [3:0]  bit_index;
		logic [7:0]  shift_byte;
		logic [7:0]  bytes_left;
		op_t         op;
		logic [7:0]  addr;
		logic [7:0]  reg_byte;
		xfer_stage_t stage;
	} bus_state_t;

	typedef struct {
		logic [7:0] hold;
		logic [7:0] bit_len;
		logic [7:0] stored;
	} bus_timing_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	i2cm_item_if item_ch();
	i2cm_result_if result_ch();

	i2c_master_register_access_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.item(item_ch),
		.result(result_ch)
	);

	bus_timing_t timing;
	bus_state_t model_bus;
	bus_state_t gen_bus;
	in_item_t tick_queue[$];
	out_item_t bus_out_due[$];
	int ticks_issued = 0;
	int ticks_taken = 0;
	int mismatches = 0;
	int gap_pct = 0;
	int stall_pct = 0;
	bit in_fire = 1'b0;
	bit hold_go = 1'b0;
	bit hold_active = 1'b0;

	function automatic bus_state_t idle_bus();
		bus_state_t s;
		s.phase = SEQ_IDLE;
		s.tick_count = '0;
		s.bit_index = '0;
		s.shift_byte = '0;
		s.bytes_left = '0;
		s.op = OP_WRITE_ONE;
		s.addr = '0;
		s.reg_byte = '0;
		s.stage = XFER_ADDR_W;
		return s;
	endfunction

	function automatic out_item_t bus_tick(ref bus_state_t s, input bus_timing_t t,
		input in_item_t w);
		out_item_t o;
		logic b7;
		logic ackb;
		logic [7:0] len;
		o = '0;
		b7 = s.shift_byte[7];
		ackb = (s.bytes_left <= 8'd1);
		if (s.phase == SEQ_IDLE && w.request) begin
			s.op = op_t'(w.operation);
			s.addr = w.use_stored_address ? t.stored : {w.device_address, 1'b0};
			s.reg_byte = w.register_index;
			case (s.op)
				OP_WRITE_ONE, OP_READ_ONE: s.bytes_left = 8'd1;
				OP_BURST_READ: s.bytes_left = (w.byte_count == 8'd0) ? 8'd1 : w.byte_count;
				default: s.bytes_left = w.byte_count;
			endcase
			s.stage = XFER_ADDR_W;
			s.phase = SEQ_START_HI;
			s.tick_count = '0;
			s.bit_index = '0;
		end

		case (s.phase)
			SEQ_RS_LOW:   {o.scl_level, o.sda_level, o.sda_driven} = 3'b011;
			SEQ_START_HI: {o.scl_level, o.sda_level, o.sda_driven} = 3'b111;
			SEQ_START_LO: {o.scl_level, o.sda_level, o.sda_driven} = 3'b101;
			SEQ_WBIT_L:   {o.scl_level, o.sda_level, o.sda_driven} = {1'b0, b7, 1'b1};
			SEQ_WBIT_H:   {o.scl_level, o.sda_level, o.sda_driven} = {1'b1, b7, 1'b1};
			SEQ_WACK_L:   {o.scl_level, o.sda_level, o.sda_driven} = 3'b010;
			SEQ_WACK_H:   {o.scl_level, o.sda_level, o.sda_driven} = 3'b110;
			SEQ_RBIT_L:   {o.scl_level, o.sda_level, o.sda_driven} = 3'b010;
			SEQ_RBIT_H:   {o.scl_level, o.sda_level, o.sda_driven} = 3'b110;
			SEQ_RACK_L:   {o.scl_level, o.sda_level, o.sda_driven} = {1'b0, ackb, 1'b1};
			SEQ_RACK_H:   {o.scl_level, o.sda_level, o.sda_driven} = {1'b1, ackb, 1'b1};
			SEQ_STOP_PRE: {o.scl_level, o.sda_level, o.sda_driven} = 3'b001;
			SEQ_STOP_A:   {o.scl_level, o.sda_level, o.sda_driven} = 3'b101;
			SEQ_STOP_B:   {o.scl_level, o.sda_level, o.sda_driven} = 3'b111;
			default: begin
				{o.scl_level, o.sda_level, o.sda_driven} = 3'b111;
				s.phase = SEQ_IDLE;
			end
		endcase

		if (s.phase != SEQ_IDLE) begin
			o.busy_res = 1'b1;
			s.tick_count = s.tick_count + 8'd1;
			if (s.phase == SEQ_START_HI || s.phase == SEQ_START_LO ||
				s.phase == SEQ_STOP_A || s.phase == SEQ_STOP_B)
				len = t.hold;
			else
				len = t.bit_len;
			if (len == 8'd0)
				len = 8'd1;
			if (s.tick_count >= len) begin
				s.tick_count = '0;
				case (s.phase)
					SEQ_RS_LOW: s.phase = SEQ_START_HI;
					SEQ_START_HI: s.phase = SEQ_START_LO;
					SEQ_START_LO: begin
						s.shift_byte = (s.stage == XFER_ADDR_R) ? (s.addr | 8'h01)
							: (s.addr & 8'hFE);
						s.bit_index = '0;
						s.phase = SEQ_WBIT_L;
					end
					SEQ_WBIT_L: s.phase = SEQ_WBIT_H;
					SEQ_WBIT_H: begin
						s.shift_byte = {s.shift_byte[6:0], 1'b0};
						s.bit_index = s.bit_index + 4'd1;
						if (s.bit_index >= 4'd8) begin
							s.bit_index = '0;
							s.phase = SEQ_WACK_L;
						end else
							s.phase = SEQ_WBIT_L;
					end
					SEQ_WACK_L: s.phase = SEQ_WACK_H;
					SEQ_WACK_H: begin
						o.ack_missing = w.sda_in;
						if (s.stage == XFER_ADDR_W) begin
							s.stage = XFER_REG;
							s.shift_byte = s.reg_byte;
							s.phase = SEQ_WBIT_L;
						end else if (s.stage == XFER_ADDR_R) begin
							s.stage = XFER_READ;
							s.shift_byte = '0;
							s.bit_index = '0;
							s.phase = SEQ_RBIT_L;
						end else if (s.stage == XFER_REG &&
							(s.op == OP_READ_ONE || s.op == OP_BURST_READ)) begin
							s.stage = XFER_ADDR_R;
							s.phase = (s.op == OP_READ_ONE) ? SEQ_RS_LOW : SEQ_STOP_PRE;
						end else if (s.bytes_left > 8'd0) begin
							s.stage = XFER_DATA;
							s.shift_byte = w.write_data;
							o.data_taken = 1'b1;
							s.bytes_left = s.bytes_left - 8'd1;
							s.phase = SEQ_WBIT_L;
						end else begin
							s.stage = XFER_DONE;
							s.phase = SEQ_STOP_PRE;
						end
					end
					SEQ_RBIT_L: s.phase = SEQ_RBIT_H;
					SEQ_RBIT_H: begin
						s.shift_byte = {s.shift_byte[6:0], w.sda_in};
						s.bit_index = s.bit_index + 4'd1;
						if (s.bit_index >= 4'd8) begin
							s.bit_index = '0;
							o.read_valid = 1'b1;
							o.read_data = s.shift_byte;
							o.last_byte = ackb;
							s.phase = SEQ_RACK_L;
						end else
							s.phase = SEQ_RBIT_L;
					end
					SEQ_RACK_L: s.phase = SEQ_RACK_H;
					SEQ_RACK_H: begin
						if (s.bytes_left > 8'd0)
							s.bytes_left = s.bytes_left - 8'd1;
						if (s.bytes_left > 8'd0) begin
							s.shift_byte = '0;
							s.phase = SEQ_RBIT_L;
						end else begin
							s.stage = XFER_DONE;
							s.phase = SEQ_STOP_PRE;
						end
					end
					SEQ_STOP_PRE: s.phase = SEQ_STOP_A;
					SEQ_STOP_A: s.phase = SEQ_STOP_B;
					default: s.phase = (s.stage == XFER_ADDR_R) ? SEQ_START_HI : SEQ_IDLE;
				endcase
			end
		end
		return o;
	endfunction

	task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
		if (want !== got) begin
			mismatches++;
			$error("%s: expected %0h, got %0h", name, want, got);
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#200us;
		$display("Regression FAIL");
		$finish;
	end

	always @(posedge clk) begin
		out_item_t want;
		in_fire <= arst_n && item_ch.valid && item_ch.ready;
		if (arst_n && item_ch.valid && item_ch.ready) begin
			bus_out_due.push_back(bus_tick(model_bus, timing, item_ch.payload));
			ticks_taken++;
		end
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (bus_out_due.size() == 0) begin
				mismatches++;
				$error("Result word arrived with no word expected.");
			end else begin
				want = bus_out_due.pop_front();
				check_field("scl_level", 8'(want.scl_level),
					8'(result_ch.payload.scl_level));
				check_field("sda_level", 8'(want.sda_level),
					8'(result_ch.payload.sda_level));
				check_field("sda_driven", 8'(want.sda_driven),
					8'(result_ch.payload.sda_driven));
				check_field("busy_res", 8'(want.busy_res),
					8'(result_ch.payload.busy_res));
				check_field("data_taken", 8'(want.data_taken),
					8'(result_ch.payload.data_taken));
				check_field("read_data", want.read_data, result_ch.payload.read_data);
				check_field("read_valid", 8'(want.read_valid),
					8'(result_ch.payload.read_valid));
				check_field("last_byte", 8'(want.last_byte),
					8'(result_ch.payload.last_byte));
				check_field("ack_missing", 8'(want.ack_missing),
					8'(result_ch.payload.ack_missing));
			end
		end
	end

	always @(negedge clk) begin
		if (!arst_n)
			item_ch.valid <= 1'b0;
		else if (!item_ch.valid || in_fire) begin
			if (tick_queue.size() != 0 && $urandom_range(0, 99) >= gap_pct) begin
				item_ch.payload <= tick_queue.pop_front();
				item_ch.valid <= 1'b1;
			end else
				item_ch.valid <= 1'b0;
		end
	end

	always @(negedge clk)
		result_ch.ready <= arst_n && !hold_active && ($urandom_range(0, 99) >= stall_pct);

	// The long hold-off lets the input queue fill so the unit has to stall its input.
	always begin
		wait (hold_go);
		hold_active = 1'b1;
		repeat (300) @(posedge clk);
		hold_active = 1'b0;
		hold_go = 1'b0;
	end

	function automatic in_item_t random_word(sda_drive_t mode);
		in_item_t w;
		w.request = ($urandom_range(0, 3) == 0);
		w.operation = 2'($urandom_range(0, 3));
		w.use_stored_address = 1'($urandom_range(0, 1));
		w.device_address = 7'($urandom_range(0, 127));
		w.register_index = 8'($urandom_range(0, 255));
		w.byte_count = 8'($urandom_range(0, 255));
		w.write_data = 8'($urandom_range(0, 255));
		w.sda_in = (mode == SDA_NOISE) ? 1'($urandom_range(0, 1)) : (mode == SDA_NACK);
		return w;
	endfunction

	task automatic push_tick(in_item_t w);
		void'(bus_tick(gen_bus, timing, w));
		tick_queue.push_back(w);
		ticks_issued++;
	endtask

	task automatic queue_transaction(op_t op, logic use_st, logic [6:0] dev,
		logic [7:0] regi, logic [7:0] cnt, sda_drive_t mode, int lead);
		in_item_t w;
		repeat (lead) begin
			w = random_word(mode);
			w.request = 1'b0;
			push_tick(w);
		end
		w = random_word(mode);
		w.request = 1'b1;
		w.operation = op;
		w.use_stored_address = use_st;
		w.device_address = dev;
		w.register_index = regi;
		w.byte_count = cnt;
		push_tick(w);
		while (gen_bus.phase != SEQ_IDLE)
			push_tick(random_word(mode));
	endtask

	task automatic random_transaction(int cnt_cap);
		logic [7:0] cnt;
		sda_drive_t mode;
		int pick;
		if (cnt_cap >= 255 && $urandom_range(0, 15) == 0)
			cnt = 8'($urandom_range(0, 255));
		else
			cnt = 8'($urandom_range(0, (cnt_cap < 5) ? cnt_cap : 5));
		pick = $urandom_range(0, 9);
		mode = (pick == 0) ? SDA_ACK : (pick == 1) ? SDA_NACK : SDA_NOISE;
		queue_transaction(op_t'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
			7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)), cnt, mode,
			$urandom_range(0, 3));
	endtask

	task automatic drain();
		while (ticks_taken != ticks_issued || bus_out_due.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_register(cfg_reg_t idx, logic [7:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_START_STOP_HOLD: timing.hold = value;
			CFG_BIT_PHASE: timing.bit_len = value;
			default: timing.stored = value;
		endcase
	endtask

	task automatic run_phase(logic [7:0] hold, logic [7:0] bit_len, logic [7:0] stored,
		int gap, int stall, int budget, int cnt_cap, bit squeeze);
		int first;
		write_register(CFG_START_STOP_HOLD, hold);
		write_register(CFG_BIT_PHASE, bit_len);
		write_register(CFG_STORED_ADDRESS, stored);
		gap_pct = gap;
		stall_pct = stall;
		first = ticks_issued;
		while (ticks_issued - first < budget)
			random_transaction(cnt_cap);
		if (squeeze)
			hold_go = 1'b1;
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_START_STOP_HOLD;
		cfg_data = '0;
		item_ch.valid = 1'b0;
		item_ch.payload = '0;
		result_ch.ready = 1'b0;
		timing = '{hold: HOLD_RESET, bit_len: BIT_RESET, stored: 8'h00};
		model_bus = idle_bus();
		gen_bus = idle_bus();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		queue_transaction(OP_BURST_READ, 1'b0, 7'h11, 8'h80, 8'd0, SDA_NOISE, 1);
		drain();

		write_register(CFG_START_STOP_HOLD, 8'd0);
		write_register(CFG_BIT_PHASE, 8'd0);
		write_register(CFG_STORED_ADDRESS, 8'hA5);
		queue_transaction(OP_READ_ONE, 1'b1, 7'd0, 8'd255, 8'd9, SDA_NACK, 0);
		queue_transaction(OP_BURST_WRITE, 1'b0, 7'h55, 8'h3C, 8'd0, SDA_ACK, 1);
		hold_go = 1'b1;
		drain();

		run_phase(8'd1, 8'd1, 8'hFF, 60, 0, 40, 2, 1'b0);
		run_phase(8'd2, 8'd1, 8'($urandom_range(0, 255)), 0, 60, 40, 2, 1'b0);
		run_phase(8'($urandom_range(1, 3)), 8'($urandom_range(1, 2)),
			8'($urandom_range(0, 255)), 7, 7, 40, 2, 1'b0);

		repeat (10) @(posedge clk);
		if (mismatches == 0 && bus_out_due.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
